// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion wrappers, sampled on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/rtsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtsp_pkg
// types and constants of the rtsp request parser
// ----------------------------------------------------------------------------
package rtsp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] byte_kind;
        logic [2:0] method_code;
        logic [2:0] field_end;
        logic [1:0] error_code;
        logic       request_end;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [2:0] phase;
        logic [5:0] match_mask;
        logic [3:0] token_count;
        logic       pending_cr;
        logic       value_started;
        logic       halted;
    } t_state;

    // one byte through the per-phase logic
    typedef struct packed {
        t_state    st;
        t_out_item r;
    } t_plain;

    // everything one input byte produces
    typedef struct packed {
        t_state    st;
        logic [1:0] n;
        t_out_item r0;
        t_out_item r1;
    } t_step;

    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_URI     = 3'd1;
    localparam logic [2:0] PH_PROTO   = 3'd2;
    localparam logic [2:0] PH_VERSION = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;

    localparam logic [1:0] KIND_STRUCT = 2'd0;
    localparam logic [1:0] KIND_URI    = 2'd1;
    localparam logic [1:0] KIND_KEY    = 2'd2;
    localparam logic [1:0] KIND_VALUE  = 2'd3;

    localparam logic [2:0] METH_NONE = 3'd0;

    localparam logic [2:0] FEND_NONE    = 3'd0;
    localparam logic [2:0] FEND_METHOD  = 3'd1;
    localparam logic [2:0] FEND_URI     = 3'd2;
    localparam logic [2:0] FEND_REQLINE = 3'd3;
    localparam logic [2:0] FEND_HEADER  = 3'd4;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_METHOD  = 2'd1;
    localparam logic [1:0] ERR_PROTO   = 2'd2;
    localparam logic [1:0] ERR_VERSION = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam int unsigned NUM_METHODS = 6;
    localparam logic [5:0]  MATCH_ALL   = 6'h3F;
    localparam logic [3:0]  COUNT_MAX   = 4'd15;

    localparam logic [7:0] METHOD_CHAR [NUM_METHODS][8] = '{
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"D", "E", "S", "C", "R", "I", "B", "E"},
        '{"S", "E", "T", "U", "P", 8'h00, 8'h00, 8'h00},
        '{"P", "L", "A", "Y", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "A", "U", "S", "E", 8'h00, 8'h00, 8'h00},
        '{"T", "E", "A", "R", "D", "O", "W", "N"}
    };
    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd7, 4'd8, 4'd5, 4'd4, 4'd5, 4'd8
    };

    localparam logic [7:0] PROTO_CHAR [4]   = '{"R", "T", "S", "P"};
    localparam logic [3:0] PROTO_LEN        = 4'd4;
    localparam logic [7:0] VERSION_CHAR [4] = '{"1", ".", "0", 8'h00};
    localparam logic [3:0] VERSION_LEN      = 4'd3;

    localparam t_state RESET_STATE = '{
        phase:         PH_METHOD,
        match_mask:    MATCH_ALL,
        token_count:   4'd0,
        pending_cr:    1'b0,
        value_started: 1'b0,
        halted:        1'b0
    };

endpackage

// ===== rtl/core/rtsp_request_parser.sv =====
// ----------------------------------------------------------------------------
// rtsp_request_parser
// byte-wise parser of an rtsp request line and its header lines
// ----------------------------------------------------------------------------
// a byte accepted is registered in r_in, and its results then in the result queue
// throughput: one byte per cycle while the result queue has room; a non-lf
//   byte that releases a held cr can give two results for the single output port
// a held cr gives no result; the two-entry result queue decouples stalls
// reset (i_rst_n low, synchronous) empties the pipeline and returns the
//   parser to the method phase; a last byte does the same for the parser
`include "assert_macros.svh"

module rtsp_request_parser
    import rtsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    function automatic logic [7:0] f_fold(logic [7:0] b);
        return (b >= CH_LOW_A && b <= CH_LOW_Z) ? b - CASE_OFS : b;
    endfunction

    function automatic logic [3:0] f_count_up(logic [3:0] c);
        return (c == COUNT_MAX) ? c : c + 4'd1;
    endfunction

    // one byte that is not part of a line end
    function automatic t_plain f_plain(t_state s, logic [7:0] b);
        t_plain     p;
        logic [2:0] m;
        logic [7:0] fb;
        p          = '0;
        p.st       = s;
        p.r.data_byte = b;
        p.r.byte_kind = KIND_STRUCT;
        fb         = f_fold(b);
        case (s.phase)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    m = METH_NONE;
                    // lowest candidate wins
                    for (int i = NUM_METHODS - 1; i >= 0; i--) begin
                        if (s.match_mask[i] && METHOD_LEN[i] == s.token_count) begin
                            m = 3'(i + 1);
                        end
                    end
                    if (m == METH_NONE) begin
                        p.r.error_code = ERR_METHOD;
                        p.st.halted    = 1'b1;
                    end else begin
                        p.r.method_code   = m;
                        p.r.field_end     = FEND_METHOD;
                        p.st.phase        = PH_URI;
                        p.st.match_mask   = MATCH_ALL;
                        p.st.token_count  = 4'd0;
                    end
                end else begin
                    for (int i = 0; i < NUM_METHODS; i++) begin
                        if (!(s.token_count < METHOD_LEN[i] &&
                              fb == METHOD_CHAR[i][s.token_count[2:0]])) begin
                            p.st.match_mask[i] = 1'b0;
                        end
                    end
                    p.st.token_count = f_count_up(s.token_count);
                end
            end
            PH_URI: begin
                if (b == CH_SP) begin
                    p.r.field_end    = FEND_URI;
                    p.st.phase       = PH_PROTO;
                    p.st.match_mask  = MATCH_ALL;
                    p.st.token_count = 4'd0;
                end else begin
                    p.r.byte_kind = KIND_URI;
                end
            end
            PH_PROTO: begin
                if (b == CH_SLASH) begin
                    if (s.match_mask[0] && s.token_count == PROTO_LEN) begin
                        p.st.phase       = PH_VERSION;
                        p.st.match_mask  = MATCH_ALL;
                        p.st.token_count = 4'd0;
                    end else begin
                        p.r.error_code = ERR_PROTO;
                        p.st.halted    = 1'b1;
                    end
                end else begin
                    if (!(s.token_count < PROTO_LEN &&
                          fb == PROTO_CHAR[s.token_count[1:0]])) begin
                        p.st.match_mask[0] = 1'b0;
                    end
                    p.st.token_count = f_count_up(s.token_count);
                end
            end
            PH_VERSION: begin
                if (!(s.token_count < VERSION_LEN &&
                      fb == VERSION_CHAR[s.token_count[1:0]])) begin
                    p.st.match_mask[0] = 1'b0;
                end
                p.st.token_count = f_count_up(s.token_count);
            end
            PH_VALUE: begin
                if (!s.value_started && b == CH_SP) begin
                    p.r.byte_kind = KIND_STRUCT;
                end else begin
                    p.st.value_started = 1'b1;
                    p.r.byte_kind      = KIND_VALUE;
                end
            end
            default: begin
                // header key, and the unused phase codes
                if (b == CH_COLON) begin
                    p.st.phase         = PH_VALUE;
                    p.st.value_started = 1'b0;
                end else begin
                    p.r.byte_kind = KIND_KEY;
                end
            end
        endcase
        return p;
    endfunction

    // lf right after a held cr
    function automatic t_plain f_line_end(t_state s, logic [7:0] b);
        t_plain p;
        p             = '0;
        p.st          = s;
        p.r.data_byte = b;
        if (s.phase == PH_VERSION &&
            !(s.match_mask[0] && s.token_count == VERSION_LEN)) begin
            p.r.error_code = ERR_VERSION;
            p.st.halted    = 1'b1;
        end else begin
            p.r.field_end      = (s.phase == PH_VERSION) ? FEND_REQLINE : FEND_HEADER;
            p.st.phase         = PH_KEY;
            p.st.value_started = 1'b0;
        end
        return p;
    endfunction

    function automatic t_step f_step(t_state s, t_in_item x);
        t_step  o;
        t_plain p;
        t_state st;
        logic   take;
        o    = '0;
        st   = s;
        take = 1'b1;
        if (s.halted) begin
            if (x.last_byte) begin
                o.r0.data_byte = x.in_byte;
                o.n            = 2'd1;
            end
        end else begin
            if (st.pending_cr) begin
                st.pending_cr = 1'b0;
                if (x.in_byte == CH_LF) begin
                    p    = f_line_end(st, x.in_byte);
                    take = 1'b0;
                end else begin
                    p    = f_plain(st, CH_CR);
                    take = !p.st.halted;
                end
                st   = p.st;
                o.r0 = p.r;
                o.n  = 2'd1;
            end
            if (take) begin
                if (x.in_byte == CH_CR && !x.last_byte && st.phase >= PH_VERSION) begin
                    st.pending_cr = 1'b1;
                end else begin
                    p  = f_plain(st, x.in_byte);
                    st = p.st;
                    if (o.n == 2'd0) begin
                        o.r0 = p.r;
                    end else begin
                        o.r1 = p.r;
                    end
                    o.n = o.n + 2'd1;
                end
            end
        end
        o.r0.request_end = x.last_byte;
        o.r1.request_end = x.last_byte;
        o.r0.last_of_run = (o.n == 2'd1);
        o.r1.last_of_run = 1'b1;
        o.st = x.last_byte ? RESET_STATE : st;
        return o;
    endfunction

    logic      r_in_valid;
    t_in_item  r_in;
    t_state    r_st;
    t_out_item r_q [2];
    logic [1:0] r_count;

    t_out_item n_q [2];
    logic [1:0] n_count;
    t_step     w_step;
    logic      w_pop;
    logic      w_proc;
    logic [1:0] w_base;

    assign w_step = f_step(r_st, r_in);
    assign w_pop  = o_out_valid && !i_out_stall;
    assign w_base = r_count - {1'b0, w_pop};
    // results of the held byte must fit in the queue after this cycle's pop
    assign w_proc = r_in_valid && (({1'b0, w_base} + {1'b0, w_step.n}) <= 3'd2);

    assign o_in_stall  = r_in_valid && !w_proc;
    assign o_out_valid = (r_count != 2'd0);
    assign o_out       = r_q[0];

    always_comb begin
        n_q = r_q;
        if (w_pop) begin
            n_q[0] = r_q[1];
        end
        if (w_proc && w_step.n != 2'd0) begin
            n_q[w_base[0]] = w_step.r0;
            if (w_step.n == 2'd2) begin
                n_q[1] = w_step.r1;
            end
        end
        n_count = w_proc ? w_base + w_step.n : w_base;
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count    <= 2'd0;
            r_st       <= RESET_STATE;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            r_count <= n_count;
            if (w_proc) begin
                r_st <= w_step.st;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_range, r_count <= 2'd2)
    `ASSERT_IMPL(a_full_blocks, (r_count == 2'd2) && i_out_stall, !w_proc || (w_step.n == 2'd0))
    `ASSERT_NEXT(a_last_resets, w_proc && r_in.last_byte, r_st == RESET_STATE)
    `ASSERT_IMPL(a_cr_phase, r_st.pending_cr, (r_st.phase >= PH_VERSION) && !r_st.halted)

endmodule
